// ===== rtl/mbet_pkg.sv =====
// mbet_pkg: shared types and constants for the mandelbrot escape-time unit
// used by mbet_ctrl, mbet_dp and mandelbrot_escape_time_unit; no dependencies
package mbet_pkg;

  // fixed-point format of c and z
  localparam int FRAC_BITS   = 28;
  localparam int COORD_W     = 32;
  localparam int PROD_W      = 2 * COORD_W;
  localparam int COUNT_WIDTH = 16;

  localparam logic signed [COORD_W-1:0] ONE     = COORD_W'(1) << FRAC_BITS;
  localparam logic signed [COORD_W-1:0] TWO     = COORD_W'(2) << FRAC_BITS;
  localparam logic signed [COORD_W-1:0] QUARTER = COORD_W'(1) << (FRAC_BITS - 2);

  // |z|^2 >= 4 when any bit at or above this position is set
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

  // (x+1)^2 + y^2 bound for the period-2 bulb: 1/16
  localparam logic signed [PROD_W-1:0] BULB_LIM = PROD_W'(1) << (2 * FRAC_BITS - 4);

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(1000);

  typedef struct packed {
    logic signed [COORD_W-1:0] c_real;
    logic signed [COORD_W-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] escape_count;
    logic                   inside_set;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_MUL1,
    ST_CHK_SUM,
    ST_CHK_MUL2,
    ST_CHK_CMP,
    ST_IT_MUL,
    ST_IT_ADD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // take a new point
    logic mul_en;      // register the three products
    logic mul_pre;     // multiplier operands for the interior check
    logic chk_load;    // latch q, q+xm, y^2/4 and the bulb result
    logic iter_start;  // z = c, count = 0
    logic iter_step;   // z = z*z + c, count + 1
    logic res_load;    // write the result register
    logic res_limit;   // result count is the limit rather than the counter
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic known_inside;  // point lies in the cardioid or the period-2 bulb
    logic escaped;       // |z|^2 >= 4
    logic at_limit;      // count reached max_iterations
    logic stuck;         // next z equals z
  } dp_status_t;

endpackage

// ===== rtl/mbet_ctrl.sv =====
// mbet_ctrl: sequencing state machine of the escape-time unit
// depends on mbet_pkg; drives mbet_dp through dp_cmd_t, reads dp_status_t

module mbet_ctrl
  import mbet_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       point_valid,
  output logic       point_ready,
  output logic       result_valid,
  input  logic       result_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    point_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        point_ready = 1'b1;
        if (point_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHK_MUL1;
        end
      end
      ST_CHK_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_pre = 1'b1;
        state_next  = ST_CHK_SUM;
      end
      ST_CHK_SUM: begin
        cmd.chk_load = 1'b1;
        state_next   = ST_CHK_MUL2;
      end
      ST_CHK_MUL2: begin
        cmd.mul_en = 1'b1;
        state_next = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (status.known_inside) begin
          if (slot_free) begin
            cmd.res_load  = 1'b1;
            cmd.res_limit = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.iter_start = 1'b1;
          state_next     = ST_IT_MUL;
        end
      end
      ST_IT_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_IT_ADD;
      end
      ST_IT_ADD: begin
        if (status.escaped) begin
          if (slot_free) begin
            cmd.res_load = 1'b1;
            state_next   = ST_IDLE;
          end
        end else if (status.at_limit || status.stuck) begin
          if (slot_free) begin
            cmd.res_load  = 1'b1;
            cmd.res_limit = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.iter_step = 1'b1;
          state_next    = ST_IT_MUL;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mbet_dp.sv =====
// mbet_dp: datapath of the escape-time unit, three shared 32x32 multipliers,
// z registers, iteration counter, limit register and result register; uses mbet_pkg

module mbet_dp
  import mbet_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  point_t                 point,
  input  logic                   cfg_we,
  input  logic [COUNT_WIDTH-1:0] cfg_data,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  output result_t                result
);

  logic signed [COORD_W-1:0] cr, ci, zr, zi;
  logic signed [PROD_W-1:0]  p0, p1, p2;
  logic signed [PROD_W-1:0]  rhs;
  logic                      box1, bulb;
  logic [COUNT_WIDTH-1:0]    cnt, max_iter;

  logic signed [COORD_W-1:0] xm, xp, a0, a1, a2, b2;
  logic signed [PROD_W-1:0]  prod0, prod1, prod2;
  logic [PROD_W-1:0]         mag;
  logic signed [PROD_W-1:0]  diff, qsum, bsum;
  logic signed [COORD_W-1:0] q, qx, nr, ni;
  logic [COUNT_WIDTH-1:0]    res_val;

  assign xm = cr - QUARTER;
  assign xp = cr + ONE;

  // operand select: interior check or z
  assign a0 = cmd.mul_pre ? xm : zr;
  assign a1 = cmd.mul_pre ? ci : zi;
  assign a2 = cmd.mul_pre ? xp : zr;
  assign b2 = cmd.mul_pre ? xp : zi;

  assign prod0 = a0 * a0;
  assign prod1 = a1 * a1;
  assign prod2 = a2 * b2;

  // interior check terms
  assign qsum = p0 + p1;
  assign q    = qsum[FRAC_BITS +: COORD_W];
  assign qx   = q + xm;
  assign bsum = p2 + p1;

  // iteration terms
  assign mag  = PROD_W'(unsigned'(p0)) + PROD_W'(unsigned'(p1));
  assign diff = p0 - p1;
  assign nr   = diff[FRAC_BITS +: COORD_W] + cr;
  assign ni   = p2[FRAC_BITS-1 +: COORD_W] + ci;

  assign status.known_inside = (box1 && (p2 < rhs)) || bulb;
  assign status.escaped      = |mag[PROD_W-1:ESC_SHIFT];
  assign status.at_limit     = (cnt == max_iter);
  assign status.stuck        = (nr == zr) && (ni == zi);

  assign res_val = cmd.res_limit ? max_iter : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iter <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cr <= point.c_real;
      ci <= point.c_imag;
    end
    if (cmd.mul_en) begin
      p0 <= prod0;
      p1 <= prod1;
      p2 <= prod2;
    end
    if (cmd.chk_load) begin
      zr   <= q;
      zi   <= qx;
      rhs  <= p1 >>> 2;
      box1 <= (cr > -ONE) && (cr < ONE) && (ci > -ONE) && (ci < ONE);
      bulb <= (cr > -TWO) && (cr < TWO) && (ci > -TWO) && (ci < TWO)
              && (bsum < BULB_LIM);
    end else if (cmd.iter_start) begin
      zr  <= cr;
      zi  <= ci;
      cnt <= '0;
    end else if (cmd.iter_step) begin
      zr  <= nr;
      zi  <= ni;
      cnt <= cnt + 1'b1;
    end
    if (cmd.res_load) begin
      result.escape_count <= res_val;
      result.inside_set   <= (res_val == max_iter);
    end
  end

endmodule

// ===== rtl/mandelbrot_escape_time_unit.sv =====
// mandelbrot_escape_time_unit: top level of the escape-time unit
// instantiates mbet_ctrl and mbet_dp; types and constants from mbet_pkg
//
// Takes one point c (signed Q3.28, real and imaginary part) per transaction
// on the point channel and returns one transaction on the result channel: the
// escape count and an inside flag that is set when the count equals
// max_iterations. Points in the main cardioid or the period-2 bulb are found
// by a closed-form check and report max_iterations without iterating; a point
// whose z stops changing is also reported as inside. Sequence: the interior
// check runs through ST_CHK_MUL1, ST_CHK_SUM, ST_CHK_MUL2 and ST_CHK_CMP from
// acceptance to the result register; a point that is iterated then passes
// through ST_IT_MUL and ST_IT_ADD once per iteration plus one more pass for
// the exit test. In the z update loop the three 32x32 multipliers are
// registered, and the add, escape test and z update follow in the next cycle.
// One point is worked on at a time; the next point can be accepted as soon as
// the result is in the output register, even if the consumer has not taken it
// yet. max_iterations (reset 1000) is written on the cfg channel, which is
// always ready; write it only while the unit is idle.

module mandelbrot_escape_time_unit
  import mbet_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // point channel
  input  logic                   point_valid,
  output logic                   point_ready,
  input  point_t                 point,
  // result channel
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  // configuration: max_iterations
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [COUNT_WIDTH-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // limit register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencing: check, iterate unless the check finds the point inside, then hand over to the output register
  mbet_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_ready  (point_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .cmd          (cmd)
  );

  // arithmetic, counter, limit and result storage
  mbet_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .point    (point),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

endmodule
